>>> src/mm_pkg.sv
package mm_pkg;

   // sizes
   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int DATA_W    = 32;
   localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;
   localparam int CSR_IDX_W = 2;

   // transaction kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 2'd2;

   // one multiply-accumulate step travelling down the datapath
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             use_prod;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_elem;
   } step_type;

   // effective matrix sizes
   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
   } dims_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // a size register above the store size acts as the store size
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

   // store entry of an element
   function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

endpackage

>>> src/mm_ram.sv
module mm_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [mm_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [mm_pkg::DATA_W-1:0]  wr_data,
   input  logic [mm_pkg::ADDR_W-1:0]  rd_addr,
   output logic [mm_pkg::DATA_W-1:0]  rd_data
);
   import mm_pkg::*;

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/mm_seq.sv
module mm_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  mm_pkg::dims_type          dims,
   output mm_pkg::step_type          step,
   output logic [mm_pkg::ADDR_W-1:0] a_rd_addr,
   output logic [mm_pkg::ADDR_W-1:0] b_rd_addr,
   output logic                      running
);
   import mm_pkg::*;

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             last_k;
   logic             last_j;
   logic             last_i;

   // state and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // end of each loop; an empty inner dimension still takes one zero step
   assign last_k = (dims.inner == '0) || (DIM_W'(k_ff) + DIM_W'(1) == dims.inner);
   assign last_j = (DIM_W'(j_ff) + DIM_W'(1) == dims.cols);
   assign last_i = (DIM_W'(i_ff) + DIM_W'(1) == dims.rows);

   // walk result row-major, inner index fastest
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      step     = '0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (go) begin
               state_in = SEQ_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         SEQ_RUN: begin
            step.valid     = 1'b1;
            step.first     = (k_ff == '0);
            step.last_k    = last_k;
            step.use_prod  = (dims.inner != '0);
            step.row       = i_ff;
            step.col       = j_ff;
            step.last_elem = last_k && last_j && last_i;
            if (!last_k) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               k_in = '0;
               if (!last_j) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (!last_i) begin
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     i_in     = '0;
                     state_in = SEQ_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign a_rd_addr = mem_addr(i_ff, k_ff);
   assign b_rd_addr = mem_addr(k_ff, j_ff);
   assign running   = (state_ff == SEQ_RUN);

endmodule

>>> src/mm_mac.sv
module mm_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  mm_pkg::step_type          step_in,
   input  logic [mm_pkg::DATA_W-1:0] a_data,
   input  logic [mm_pkg::DATA_W-1:0] b_data,
   output logic                      rsp_strobe,
   output logic [mm_pkg::IDX_W-1:0]  rsp_out_row,
   output logic [mm_pkg::IDX_W-1:0]  rsp_out_col,
   output logic [mm_pkg::DATA_W-1:0] rsp_out_value,
   output logic                      rsp_last,
   output logic                      pipe_busy
);
   import mm_pkg::*;

   step_type                   step1_ff, step2_ff, step3_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    shifted;
   logic [ACC_W-DATA_W:0]      hi_bits;
   logic [DATA_W-1:0]          sat_value;
   logic                       strobe_ff, strobe_in;
   logic [IDX_W-1:0]           row_ff, col_ff;
   logic [DATA_W-1:0]          value_ff;
   logic                       last_ff;

   // step control alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         step1_ff  <= '0;
         step2_ff  <= '0;
         step3_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         step1_ff  <= step_in;
         step2_ff  <= step1_ff;
         step3_ff  <= step2_ff;
         strobe_ff <= strobe_in;
      end
   end

   // product of the two store words, zero for an empty inner dimension
   always_comb begin
      if (step1_ff.use_prod) begin
         prod_in = $signed(a_data) * $signed(b_data);
      end else begin
         prod_in = '0;
      end
   end

   // wide accumulation, restarted on the first step of each element
   always_comb begin
      acc_in = acc_ff;
      if (step2_ff.valid) begin
         acc_in = (step2_ff.first ? ACC_W'(0) : acc_ff)
                + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // floor shift to Q16.16 and saturate
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      hi_bits = shifted[ACC_W-1:DATA_W-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         sat_value = shifted[DATA_W-1:0];
      end else if (hi_bits[ACC_W-DATA_W]) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // result register
   assign strobe_in = step3_ff.valid && step3_ff.last_k;

   always_ff @(posedge clock) begin
      if (strobe_in) begin
         row_ff   <= step3_ff.row;
         col_ff   <= step3_ff.col;
         value_ff <= sat_value;
         last_ff  <= step3_ff.last_elem;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = strobe_ff && last_ff;
   assign pipe_busy     = step1_ff.valid || step2_ff.valid || step3_ff.valid;

endmodule

>>> src/matrix_multiply.sv
// matrix_multiply: C = A x B on signed Q16.16 elements, up to 8 x 8.
//
// Configuration: csr_index selects rows_a (0), inner_dim (1) or cols_b (2);
// a write is taken when csr_valid and csr_ready are high (csr_ready is always
// high). Write only while busy is low. Sizes above 8 act as 8.
// Requests: a transaction is taken when start is high and busy is low.
// Kind 0 and 1 write one element of A or B and leave busy
// low; out-of-range loads and kind 3 are dropped. Kind 2 runs the product.
// A product walks the result row-major through one multiply-accumulate unit,
// reading one word of each store per cycle. A zero rows_a or cols_b gives no
// results. Each result shows for one cycle with rsp_strobe; rsp_last marks
// the final element. The receiver cannot stall, so there is no back-pressure.
// Reset sets all sizes to 8 and clears the sequencer; store contents are
// undefined until loaded.
module matrix_multiply (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [mm_pkg::IDX_W-1:0]     req_row,
   input  logic [mm_pkg::IDX_W-1:0]     req_col,
   input  logic [mm_pkg::DATA_W-1:0]    req_value,
   output logic                         rsp_strobe,
   output logic [mm_pkg::IDX_W-1:0]     rsp_out_row,
   output logic [mm_pkg::IDX_W-1:0]     rsp_out_col,
   output logic [mm_pkg::DATA_W-1:0]    rsp_out_value,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mm_pkg::DIM_W-1:0]     csr_data
);
   import mm_pkg::*;

   logic [DIM_W-1:0]  rows_a_ff, rows_a_in;
   logic [DIM_W-1:0]  inner_dim_ff, inner_dim_in;
   logic [DIM_W-1:0]  cols_b_ff, cols_b_in;
   dims_type          dims;
   logic              req_take;
   logic              a_wr_en;
   logic              b_wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              go;
   step_type          step;
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   logic [DATA_W-1:0] a_data, b_data;
   logic              seq_running;
   logic              pipe_busy;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROWS_A:    rows_a_in    = csr_data;
            REG_INNER_DIM: inner_dim_in = csr_data;
            REG_COLS_B:    cols_b_in    = csr_data;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_W'(MAX_DIM);
         inner_dim_ff <= DIM_W'(MAX_DIM);
         cols_b_ff    <= DIM_W'(MAX_DIM);
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   assign dims.rows  = eff_dim(rows_a_ff);
   assign dims.inner = eff_dim(inner_dim_ff);
   assign dims.cols  = eff_dim(cols_b_ff);

   // request decode; loads are range-checked against the current sizes
   assign req_take = start && !busy;
   assign wr_addr  = mem_addr(req_row, req_col);
   assign a_wr_en  = req_take && (req_kind == KIND_LOAD_A)
                  && (DIM_W'(req_row) < dims.rows) && (DIM_W'(req_col) < dims.inner);
   assign b_wr_en  = req_take && (req_kind == KIND_LOAD_B)
                  && (DIM_W'(req_row) < dims.inner) && (DIM_W'(req_col) < dims.cols);
   assign go       = req_take && (req_kind == KIND_START)
                  && (dims.rows != '0) && (dims.cols != '0);

   // element stores
   mm_ram u_store_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   mm_ram u_store_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   // result walk
   mm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .dims      (dims),
      .step      (step),
      .a_rd_addr (a_rd_addr),
      .b_rd_addr (b_rd_addr),
      .running   (seq_running)
   );

   // multiply-accumulate and saturation
   mm_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .step_in       (step),
      .a_data        (a_data),
      .b_data        (b_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last),
      .pipe_busy     (pipe_busy)
   );

   // stores are not written while reads are in flight
   assign busy = seq_running || pipe_busy;

endmodule

>>> src/mm_checker.sv
module mm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [1:0]                   req_kind,
   input logic                         rsp_strobe,
   input logic                         rsp_last,
   input logic                         csr_valid,
   input logic                         csr_ready
);
   import mm_pkg::*;

   // a result only comes out of a product in progress
   a_strobe_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a product in progress");

   // loads leave busy low
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind != KIND_START) |=> !busy)
      else $error("load transaction raised busy");

   // busy only rises on an accepted transaction
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");

   // the final element closes the product
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result after the final element");

   // sizes only change while the block is quiet
   a_csr_when_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy)
      else $error("register write while a product is in progress");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

>>> dv/matrix_multiply_test.sv
`timescale 1ns / 100ps

// one element of the product as it leaves the block
typedef struct packed {
   logic [mm_pkg::IDX_W-1:0]  row;
   logic [mm_pkg::IDX_W-1:0]  col;
   logic [mm_pkg::DATA_W-1:0] value;
   logic                      last;
} mm_result_type;

// shadow copy of the sizes and stores, and the queue of product elements still due
class mm_scoreboard;
   logic [mm_pkg::DIM_W-1:0]  reg_rows;
   logic [mm_pkg::DIM_W-1:0]  reg_inner;
   logic [mm_pkg::DIM_W-1:0]  reg_cols;
   logic [mm_pkg::DATA_W-1:0] a_store [mm_pkg::MEM_DEPTH];
   logic [mm_pkg::DATA_W-1:0] b_store [mm_pkg::MEM_DEPTH];
   bit                        a_written [mm_pkg::MEM_DEPTH];
   bit                        b_written [mm_pkg::MEM_DEPTH];
   mm_result_type             due_q [$];
   int                        errors;
   int                        checked;
   int                        products;
   int                        requests;

   function new();
      reg_rows  = 4'd8;
      reg_inner = 4'd8;
      reg_cols  = 4'd8;
      for (int i = 0; i < mm_pkg::MEM_DEPTH; i++) begin
         a_written[i] = 1'b0;
         b_written[i] = 1'b0;
      end
      errors   = 0;
      checked  = 0;
      products = 0;
      requests = 0;
   endfunction

   function int pending();
      return due_q.size();
   endfunction

   // sizes above the store act as the store size
   function int unsigned clamp_size(logic [mm_pkg::DIM_W-1:0] v);
      return (v > mm_pkg::MAX_DIM) ? mm_pkg::MAX_DIM : int'(v);
   endfunction

   function void write_reg(logic [mm_pkg::CSR_IDX_W-1:0] idx, logic [mm_pkg::DIM_W-1:0] data);
      case (idx)
         mm_pkg::REG_ROWS_A:    reg_rows  = data;
         mm_pkg::REG_INNER_DIM: reg_inner = data;
         mm_pkg::REG_COLS_B:    reg_cols  = data;
         default: ;
      endcase
   endfunction

   // wide sum of exact products, floor shift, saturate to 32 bits
   function logic [mm_pkg::DATA_W-1:0] dot_product(int unsigned i, int unsigned j,
                                                   int unsigned kn);
      logic signed [71:0] acc;
      logic signed [71:0] shifted;
      longint             prod;
      acc = '0;
      for (int unsigned k = 0; k < kn; k++) begin
         prod = longint'($signed(a_store[i * mm_pkg::MAX_DIM + k])) *
                longint'($signed(b_store[k * mm_pkg::MAX_DIM + j]));
         acc  = acc + {{8{prod[63]}}, prod};
      end
      shifted = acc >>> mm_pkg::FRAC_BITS;
      if (shifted > 72'sd2147483647)
         return 32'h7FFF_FFFF;
      if (shifted < -72'sd2147483648)
         return 32'h8000_0000;
      return shifted[31:0];
   endfunction

   // apply one accepted transaction; returns 1 when it did anything
   function bit note_request(logic [1:0] kind, logic [mm_pkg::IDX_W-1:0] row,
                             logic [mm_pkg::IDX_W-1:0] col, logic [mm_pkg::DATA_W-1:0] value);
      int unsigned   nr;
      int unsigned   nk;
      int unsigned   nc;
      int            addr;
      mm_result_type elem;
      nr   = clamp_size(reg_rows);
      nk   = clamp_size(reg_inner);
      nc   = clamp_size(reg_cols);
      addr = int'(row) * mm_pkg::MAX_DIM + int'(col);
      requests++;
      case (kind)
         mm_pkg::KIND_LOAD_A: begin
            if (row < nr && col < nk) begin
               a_store[addr]   = value;
               a_written[addr] = 1'b1;
               return 1'b1;
            end
         end
         mm_pkg::KIND_LOAD_B: begin
            if (row < nk && col < nc) begin
               b_store[addr]   = value;
               b_written[addr] = 1'b1;
               return 1'b1;
            end
         end
         mm_pkg::KIND_START: begin
            products++;
            for (int unsigned i = 0; i < nr; i++) begin
               for (int unsigned j = 0; j < nc; j++) begin
                  elem.row   = i[2:0];
                  elem.col   = j[2:0];
                  elem.value = dot_product(i, j, nk);
                  elem.last  = (i == nr - 1 && j == nc - 1);
                  due_q.push_back(elem);
               end
            end
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task report_mismatch(string what);
      errors++;
      if (errors <= 40)
         $display("mismatch: %s", what);
   endtask

   task check_result(logic [mm_pkg::IDX_W-1:0] row, logic [mm_pkg::IDX_W-1:0] col,
                     logic [mm_pkg::DATA_W-1:0] value, logic last);
      mm_result_type want;
      if (due_q.size() == 0) begin
         report_mismatch($sformatf("unexpected element (%0d,%0d) value %h last %b",
                                   row, col, value, last));
         return;
      end
      want = due_q.pop_front();
      checked++;
      if (row !== want.row)
         report_mismatch($sformatf("row %0d, wanted %0d", row, want.row));
      if (col !== want.col)
         report_mismatch($sformatf("col %0d, wanted %0d at row %0d", col, want.col, want.row));
      if (value !== want.value)
         report_mismatch($sformatf("value %h, wanted %h at (%0d,%0d)",
                                   value, want.value, want.row, want.col));
      if (last !== want.last)
         report_mismatch($sformatf("last %b, wanted %b at (%0d,%0d)",
                                   last, want.last, want.row, want.col));
   endtask
endclass

module matrix_multiply_test;
   import mm_pkg::*;

   localparam logic [1:0]           KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 2'd3;
   localparam int                   CYCLE_LIMIT = 400000;
   localparam int                   DRAIN       = 16;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_kind;
   logic [IDX_W-1:0]     req_row;
   logic [IDX_W-1:0]     req_col;
   logic [DATA_W-1:0]    req_value;
   logic                 rsp_strobe;
   logic [IDX_W-1:0]     rsp_out_row;
   logic [IDX_W-1:0]     rsp_out_col;
   logic [DATA_W-1:0]    rsp_out_value;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_data;

   mm_scoreboard sb;
   int           idle_pct;
   int           random_items;
   int           size_writes;
   int           cycle_count;

   matrix_multiply u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result transactions are taken on every strobe
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_out_row, rsp_out_col, rsp_out_value, rsp_last);
   end

   // mostly extremes and small Q16.16 values, the rest full range
   function automatic logic [DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3, 4:    return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
         default: return $urandom();
      endcase
   endfunction

   // size register: mostly small, sometimes zero
   function automatic logic [DIM_W-1:0] pick_size();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return 4'd0;
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   // size register at the store size or above it
   function automatic logic [DIM_W-1:0] pick_big();
      return $urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(9, 15));
   endfunction

   // one request transaction, with optional idle cycles in front
   task automatic send_item(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct && gap < 40) begin
         if (start)
            start <= 1'b0;
         @(posedge clock);
         gap++;
      end
      start     <= 1'b1;
      req_kind  <= kind;
      req_row   <= row;
      req_col   <= col;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (sb.note_request(kind, row, col, value))
         random_items++;
   endtask

   // register write; valid stays high for back-to-back writes
   task automatic write_size(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      size_writes++;
   endtask

   task automatic set_sizes(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                            input logic [DIM_W-1:0] c);
      write_size(REG_ROWS_A, r);
      write_size(REG_INNER_DIM, k);
      write_size(REG_COLS_B, c);
      csr_valid <= 1'b0;
   endtask

   // let every due element arrive and the block go quiet
   task automatic wait_drained();
      if (start)
         start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // load the operand region the current sizes read, all of it or only unwritten entries
   task automatic fill_operands(input bit whole);
      int unsigned nr;
      int unsigned nk;
      int unsigned nc;
      nr = sb.clamp_size(sb.reg_rows);
      nk = sb.clamp_size(sb.reg_inner);
      nc = sb.clamp_size(sb.reg_cols);
      for (int unsigned i = 0; i < nr; i++)
         for (int unsigned k = 0; k < nk; k++)
            if (whole || !sb.a_written[i * MAX_DIM + k])
               send_item(KIND_LOAD_A, i[2:0], k[2:0], pick_value());
      for (int unsigned k = 0; k < nk; k++)
         for (int unsigned j = 0; j < nc; j++)
            if (whole || !sb.b_written[k * MAX_DIM + j])
               send_item(KIND_LOAD_B, k[2:0], j[2:0], pick_value());
   endtask

   // one random setting followed by a few products
   task automatic run_phase(input int p);
      logic [DIM_W-1:0] r;
      logic [DIM_W-1:0] k;
      logic [DIM_W-1:0] c;
      int               sel;
      case (p % 3)
         0:       idle_pct = 0;
         1:       idle_pct = 84;
         default: idle_pct = 7;
      endcase
      if (p == 1) begin
         // full inner dimension summed into a single element
         r = 4'd1;
         k = pick_big();
         c = 4'd1;
      end else if (p == 2) begin
         // full result, one product term per element
         r = pick_big();
         k = 4'd1;
         c = pick_big();
      end else begin
         r = pick_size();
         k = pick_size();
         c = pick_size();
      end
      set_sizes(r, k, c);
      repeat ($urandom_range(1, 3)) begin
         fill_operands($urandom_range(0, 1));
         // loose loads, many out of range at small sizes, and unused kinds
         repeat ($urandom_range(0, 6)) begin
            sel = $urandom_range(0, 9);
            if (sel < 8)
               send_item(sel[0] ? KIND_LOAD_B : KIND_LOAD_A, 3'($urandom_range(0, 7)),
                         3'($urandom_range(0, 7)), pick_value());
            else
               send_item(KIND_UNUSED, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         $urandom());
         end
         send_item(KIND_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom());
      end
      wait_drained();
   endtask

   initial begin
      int p;
      sb           = new();
      idle_pct     = 0;
      random_items = 0;
      size_writes  = 0;
      cycle_count  = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_kind  <= KIND_LOAD_A;
      req_row   <= '0;
      req_col   <= '0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_ROWS_A;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unused kind and corner loads at the reset sizes
      send_item(KIND_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_item(KIND_LOAD_A, 3'd7, 3'd7, 32'h8000_0000);
      send_item(KIND_LOAD_B, 3'd7, 3'd7, 32'h7FFF_FFFF);
      wait_drained();

      // 1x1x1: saturation both ways and the floor of a negative product
      write_size(REG_UNUSED, 4'hF);
      set_sizes(4'd1, 4'd1, 4'd1);
      send_item(KIND_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_item(KIND_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_item(KIND_START, 3'd0, 3'd0, 32'h0);
      send_item(KIND_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
      send_item(KIND_START, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_item(KIND_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
      send_item(KIND_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
      send_item(KIND_START, 3'd5, 3'd2, 32'h1234_5678);

      // loads just outside the 1x1 sizes are dropped
      send_item(KIND_LOAD_A, 3'd1, 3'd0, 32'h7FFF_FFFF);
      send_item(KIND_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
      send_item(KIND_LOAD_B, 3'd1, 3'd0, 32'h8000_0000);
      send_item(KIND_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
      send_item(KIND_START, 3'd0, 3'd0, 32'h0);
      wait_drained();

      // zero inner dimension gives zeros, zero rows or columns give nothing
      set_sizes(4'd2, 4'd0, 4'd2);
      send_item(KIND_START, 3'd0, 3'd0, 32'h0);
      wait_drained();
      set_sizes(4'd0, 4'd3, 4'd3);
      send_item(KIND_START, 3'd0, 3'd0, 32'h0);
      wait_drained();
      set_sizes(4'd3, 4'd3, 4'd0);
      send_item(KIND_START, 3'd0, 3'd0, 32'h0);
      wait_drained();

      // random phases across the idle modes
      p = 0;
      while (sb.requests < 110 || p < 3) begin
         run_phase(p);
         p++;
      end

      idle_pct = 0;
      wait_drained();
      repeat (64) @(posedge clock);

      $display("checked %0d product elements from %0d products, %0d request transactions (%0d took effect)",
               sb.checked, sb.products, sb.requests, random_items);
      $display("%0d size register writes, %0d random phases, sizes 0 to 15", size_writes, p);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
